@@ hdl/msix_interrupt_cause_mask_unit_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the MSI-X interrupt cause/mask unit
// Shared property forms, clocked on i_clk and qualified by i_rst_n.
// ----------------------------------------------------------------------------
`ifndef MSIX_INTERRUPT_CAUSE_MASK_UNIT_ASSERT_SVH
`define MSIX_INTERRUPT_CAUSE_MASK_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define MICM_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset
`define MICM_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

// Next-cycle implication that also checks through reset
`define MICM_ASSERT_RST(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) else $error(msg);

`endif

@@ hdl/micm_pkg.sv @@
// ----------------------------------------------------------------------------
// micm_pkg
// Types and constants shared by the interrupt cause/mask unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package micm_pkg;

    localparam int NUM_VEC    = 3;
    localparam int VEC_W      = 2;
    localparam int MAP_W      = 8;
    localparam int MAP_VALID  = 7;
    localparam int QUEUE_W    = 16;
    localparam int TX_OFFSET  = 8;
    localparam int QMAP_W     = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int OP_W       = 3;

    localparam logic [VEC_W-1:0]   VEC_INVALID  = 2'd3;
    localparam logic [NUM_VEC-1:0] TBL_MASK_RST = 3'b111;

    typedef enum logic [OP_W-1:0] {
        OP_RX_EVT    = 3'd0,
        OP_TX_EVT    = 3'd1,
        OP_MISC_EVT  = 3'd2,
        OP_RETRIGGER = 3'd3,
        OP_SET_EN    = 3'd4,
        OP_CLR_CAUSE = 3'd5
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_QUEUE_MAP = 3'd0,
        CFG_MISC_MAP  = 3'd1,
        CFG_AUTO_CLR  = 3'd2,
        CFG_AUTO_MSK  = 3'd3,
        CFG_TBL_MASK  = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic [QMAP_W-1:0]  queue_map;
        logic [MAP_W-1:0]   misc_map;
        logic [NUM_VEC-1:0] auto_clr;
        logic [NUM_VEC-1:0] auto_msk;
        logic [NUM_VEC-1:0] tbl_mask;
    } t_cfg;

    typedef struct packed {
        logic [NUM_VEC-1:0] fired;
        logic [NUM_VEC-1:0] cause;
        logic [NUM_VEC-1:0] enable;
    } t_evt_res;

endpackage

@@ hdl/micm_in_if.sv @@
// ----------------------------------------------------------------------------
// micm_in_if
// Event channel: valid/ready handshake carrying op, queue and bitmap.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface micm_in_if;
    logic       valid;
    logic       ready;
    logic [2:0] op;
    logic       queue;
    logic [2:0] bits;

    modport source (output valid, output op, output queue, output bits, input ready);
    modport sink   (input valid, input op, input queue, input bits, output ready);
endinterface

@@ hdl/micm_out_if.sv @@
// ----------------------------------------------------------------------------
// micm_out_if
// Result channel: valid/ready handshake carrying fired, cause and enable.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface micm_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] fired;
    logic [2:0] cause_now;
    logic [2:0] enable_now;

    modport source (output valid, output fired, output cause_now, output enable_now,
                    input ready);
    modport sink   (input valid, input fired, input cause_now, input enable_now,
                    output ready);
endinterface

@@ hdl/micm_core.sv @@
// ----------------------------------------------------------------------------
// micm_core
// Evaluates one event against the cause and enable registers: picks the
// raised vectors, fires the enabled unmasked ones, applies auto-clear/mask.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module micm_core (
    input  logic [micm_pkg::OP_W-1:0]    i_op,
    input  logic                         i_queue,
    input  logic [micm_pkg::NUM_VEC-1:0] i_bits,
    input  logic [micm_pkg::NUM_VEC-1:0] i_cause,
    input  logic [micm_pkg::NUM_VEC-1:0] i_enable,
    input  micm_pkg::t_cfg               i_cfg,
    output micm_pkg::t_evt_res           o_res
);
    import micm_pkg::*;

    logic [QUEUE_W-1:0] queue_half;
    logic [MAP_W-1:0]   map_byte;
    logic [VEC_W-1:0]   map_vec;
    logic               map_ok;
    logic [NUM_VEC-1:0] raise;
    logic [NUM_VEC-1:0] cause_set;
    logic [NUM_VEC-1:0] fire;

    // Select the allocation byte for the event
    always_comb begin
        queue_half = i_queue ? i_cfg.queue_map[2*QUEUE_W-1:QUEUE_W]
                             : i_cfg.queue_map[QUEUE_W-1:0];
        case (i_op)
            OP_RX_EVT: map_byte = queue_half[MAP_W-1:0];
            OP_TX_EVT: map_byte = queue_half[TX_OFFSET +: MAP_W];
            default:   map_byte = i_cfg.misc_map;
        endcase
        map_vec = map_byte[VEC_W-1:0];
        map_ok  = map_byte[MAP_VALID] && (map_vec != VEC_INVALID);
    end

    // Raised vectors: the mapped one, or every pending cause on retrigger
    always_comb begin
        case (i_op)
            OP_RX_EVT, OP_TX_EVT, OP_MISC_EVT: begin
                raise = map_ok ? (NUM_VEC'(1) << map_vec) : '0;
            end
            OP_RETRIGGER: raise = i_cause;
            default:      raise = '0;
        endcase
    end

    // Fire, then apply auto-clear and auto-mask; register writes otherwise
    always_comb begin
        cause_set = i_cause | raise;
        fire      = raise & i_enable & ~i_cfg.tbl_mask;
        o_res.fired  = fire;
        o_res.cause  = cause_set & ~(fire & i_cfg.auto_clr);
        o_res.enable = i_enable & ~(fire & i_cfg.auto_msk);
        case (i_op)
            OP_SET_EN:    o_res.enable = i_enable | i_bits;
            OP_CLR_CAUSE: o_res.cause  = i_cause & ~i_bits;
            default: begin
            end
        endcase
    end

endmodule

@@ hdl/msix_interrupt_cause_mask_unit.sv @@
// ----------------------------------------------------------------------------
// msix_interrupt_cause_mask_unit
// Interrupt cause/mask unit for a virtual function with three MSI-X vectors.
// ----------------------------------------------------------------------------
// Takes one event word per clock while unstalled and returns one result word
// per event, in order. An accepted event is held in the input register, is
// evaluated against the cause and enable registers and lands in the result
// register, so each result passes through the input and result registers.
// Throughput is one event per clock when the result side is not stalled, set
// by the input/result register pair; a stalled result register holds its word
// and back-pressures the input once the input register is also full.
// Configuration writes are expected only while no event is in flight.
`timescale 1ns / 1ps

module msix_interrupt_cause_mask_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    micm_in_if.sink                           i_evt,
    micm_out_if.source                        o_res,
    input  logic                              i_cfg_we,
    input  logic [micm_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [micm_pkg::CFG_DATA_W-1:0]   i_cfg_wdata
);
    import micm_pkg::*;

    t_cfg               r_cfg;
    logic [NUM_VEC-1:0] r_cause;
    logic [NUM_VEC-1:0] r_enable;

    logic               r_in_vld;
    logic [OP_W-1:0]    r_in_op;
    logic               r_in_queue;
    logic [NUM_VEC-1:0] r_in_bits;

    logic               r_out_vld;
    t_evt_res           r_out;

    t_evt_res           n_res;
    logic               in_take;
    logic               out_free;
    logic               stage_go;

    // Handshake: input register drains when the result register frees up
    assign out_free    = !r_out_vld || o_res.ready;
    assign stage_go    = r_in_vld && out_free;
    assign i_evt.ready = !r_in_vld || out_free;
    assign in_take     = i_evt.valid && i_evt.ready;

    // Hold configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.queue_map <= '0;
            r_cfg.misc_map  <= '0;
            r_cfg.auto_clr  <= '0;
            r_cfg.auto_msk  <= '0;
            r_cfg.tbl_mask  <= TBL_MASK_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_QUEUE_MAP: r_cfg.queue_map <= i_cfg_wdata[QMAP_W-1:0];
                CFG_MISC_MAP:  r_cfg.misc_map  <= i_cfg_wdata[MAP_W-1:0];
                CFG_AUTO_CLR:  r_cfg.auto_clr  <= i_cfg_wdata[NUM_VEC-1:0];
                CFG_AUTO_MSK:  r_cfg.auto_msk  <= i_cfg_wdata[NUM_VEC-1:0];
                CFG_TBL_MASK:  r_cfg.tbl_mask  <= i_cfg_wdata[NUM_VEC-1:0];
                default: begin
                end
            endcase
        end
    end

    // Capture the event word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (in_take) begin
            r_in_vld <= 1'b1;
        end else if (stage_go) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_op    <= i_evt.op;
            r_in_queue <= i_evt.queue;
            r_in_bits  <= i_evt.bits;
        end
    end

    // Evaluate the event
    micm_core u_core (
        .i_op     (r_in_op),
        .i_queue  (r_in_queue),
        .i_bits   (r_in_bits),
        .i_cause  (r_cause),
        .i_enable (r_enable),
        .i_cfg    (r_cfg),
        .o_res    (n_res)
    );

    // Advance cause and enable state with each evaluated event
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cause  <= '0;
            r_enable <= '0;
        end else if (stage_go) begin
            r_cause  <= n_res.cause;
            r_enable <= n_res.enable;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (stage_go) begin
            r_out_vld <= 1'b1;
        end else if (o_res.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (stage_go) begin
            r_out <= n_res;
        end
    end

    assign o_res.valid      = r_out_vld;
    assign o_res.fired      = r_out.fired;
    assign o_res.cause_now  = r_out.cause;
    assign o_res.enable_now = r_out.enable;

endmodule

@@ hdl/micm_checker.sv @@
// ----------------------------------------------------------------------------
// micm_checker
// Port-level checks for the interrupt cause/mask unit, bound to the top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "msix_interrupt_cause_mask_unit_assert.svh"

module micm_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [2:0] i_fired,
    input logic [2:0] i_cause_now,
    input logic [2:0] i_enable_now
);

    // A stalled result word holds
    `MICM_ASSERT_NXT(a_out_hold, i_out_valid && !i_out_ready, i_out_valid && $stable({i_fired, i_cause_now, i_enable_now}), "result word changed while stalled")

    // With the result register empty the input side is never blocked
    `MICM_ASSERT_IMP(a_no_block, !i_out_valid, i_in_ready, "input stalled with empty result register")

    // An event taken into an empty unit passes the input register, then yields a result
    `MICM_ASSERT_NXT(a_latency, i_in_valid && i_in_ready && !i_out_valid && $past(i_in_ready), ##1 i_out_valid, "result missing after accepted word")

    // Reset empties the result register
    `MICM_ASSERT_RST(a_rst_empty, !i_rst_n, !i_out_valid, "result valid after reset")

endmodule

bind msix_interrupt_cause_mask_unit micm_checker u_micm_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_evt.valid),
    .i_in_ready   (i_evt.ready),
    .i_out_valid  (o_res.valid),
    .i_out_ready  (o_res.ready),
    .i_fired      (o_res.fired),
    .i_cause_now  (o_res.cause_now),
    .i_enable_now (o_res.enable_now)
);

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the MSI-X interrupt cause/mask unit. A short directed
// table covers reset state, unmapped events, the invalid vector code, table
// masking, auto-clear, auto-mask and unused op codes. Several random phases
// follow, each with its own register setting and one of four idling patterns.
// Accepted results are checked against table rows or a cycle-free shadow model.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

    import micm_pkg::*;

    // Op codes and register index that the package leaves unnamed
    localparam logic [OP_W-1:0]      OP_SPARE_6   = 3'd6;
    localparam logic [OP_W-1:0]      OP_SPARE_7   = 3'd7;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_NONE = 3'd7;

    localparam int STALL_LIMIT    = 5000;
    localparam int SETTLE_CYCLES  = 4;
    localparam int NUM_PHASES     = 8;
    localparam int WORDS_PER_PHASE = 75;

    typedef struct {
        logic                  is_cfg;
        logic [OP_W-1:0]       code;
        logic                  queue;
        logic [NUM_VEC-1:0]    bits;
        logic [CFG_DATA_W-1:0] wdata;
        logic                  check;
        t_evt_res              res;
    } t_dir_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_wdata;

    micm_in_if  evt_if ();
    micm_out_if res_if ();

    msix_interrupt_cause_mask_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_evt       (evt_if),
        .o_res       (res_if),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata)
    );

    // Shadow copy of the block's registers and state
    t_cfg               shadow_cfg;
    logic [NUM_VEC-1:0] shadow_cause;
    logic [NUM_VEC-1:0] shadow_enable;

    t_evt_res expected_results [$];
    t_dir_row dir_table [$];

    // Typed expectation that rides along with the current event word
    logic     cur_has_exp;
    t_evt_res cur_exp;

    int err_count      = 0;
    int idle_cycles    = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    // Free-running clock
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Raise one vector: set cause, fire if enabled and unmasked
    function automatic logic [NUM_VEC-1:0] raise_vector(input logic [VEC_W-1:0] vec);
        logic [NUM_VEC-1:0] sel;
        if (vec == VEC_INVALID) return '0;
        sel = 3'b001 << vec;
        shadow_cause = shadow_cause | sel;
        if ((shadow_enable & sel) != '0 && (shadow_cfg.tbl_mask & sel) == '0) begin
            shadow_cause  = shadow_cause & ~(sel & shadow_cfg.auto_clr);
            shadow_enable = shadow_enable & ~(sel & shadow_cfg.auto_msk);
            return sel;
        end
        return '0;
    endfunction

    function automatic logic [NUM_VEC-1:0] raise_map_byte(input logic [MAP_W-1:0] map);
        if (!map[MAP_VALID]) return '0;
        return raise_vector(map[VEC_W-1:0]);
    endfunction

    // Advance the shadow state by one event and return its result word
    function automatic t_evt_res predict_event(input logic [OP_W-1:0] op, input logic q,
                                               input logic [NUM_VEC-1:0] bmap);
        t_evt_res           res;
        logic [NUM_VEC-1:0] fired;
        int                 base;
        fired = '0;
        base  = q ? QUEUE_W : 0;
        case (op)
            OP_RX_EVT: begin
                fired = raise_map_byte(shadow_cfg.queue_map[base +: MAP_W]);
            end
            OP_TX_EVT: begin
                fired = raise_map_byte(shadow_cfg.queue_map[base + TX_OFFSET +: MAP_W]);
            end
            OP_MISC_EVT: begin
                fired = raise_map_byte(shadow_cfg.misc_map);
            end
            OP_RETRIGGER: begin
                for (int v = 0; v < NUM_VEC; v++)
                    if (shadow_cause[v]) fired = fired | raise_vector(v[VEC_W-1:0]);
            end
            OP_SET_EN: begin
                shadow_enable = shadow_enable | bmap;
            end
            OP_CLR_CAUSE: begin
                shadow_cause = shadow_cause & ~bmap;
            end
            default: begin
            end
        endcase
        res.fired  = fired;
        res.cause  = shadow_cause;
        res.enable = shadow_enable;
        return res;
    endfunction

    function automatic t_dir_row evt_row(input logic [OP_W-1:0] op, input logic q,
                                         input logic [NUM_VEC-1:0] bmap, input logic chk,
                                         input t_evt_res res);
        t_dir_row row;
        row.is_cfg = 1'b0;
        row.code   = op;
        row.queue  = q;
        row.bits   = bmap;
        row.wdata  = '0;
        row.check  = chk;
        row.res    = res;
        return row;
    endfunction

    function automatic t_dir_row cfg_row(input logic [CFG_IDX_W-1:0] idx,
                                         input logic [CFG_DATA_W-1:0] data);
        t_dir_row row;
        row.is_cfg = 1'b1;
        row.code   = idx;
        row.queue  = 1'b0;
        row.bits   = '0;
        row.wdata  = data;
        row.check  = 1'b0;
        row.res    = '0;
        return row;
    endfunction

    function automatic logic [MAP_W-1:0] rand_map_byte();
        logic [MAP_W-1:0] b;
        b = MAP_W'($urandom);
        if ($urandom_range(3) != 0) b[MAP_VALID] = 1'b1;
        return b;
    endfunction

    task automatic report_mismatch(input string what, input t_evt_res got,
                                   input t_evt_res want);
        $display("MISMATCH %s: got fired=%b cause=%b enable=%b, %s%b cause=%b enable=%b",
                 what, got.fired, got.cause, got.enable, "want fired=",
                 want.fired, want.cause, want.enable);
        err_count++;
    endtask

    // Write one register; the shadow copy follows at once since the block is idle
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= data;
        case (idx)
            CFG_QUEUE_MAP: shadow_cfg.queue_map = data;
            CFG_MISC_MAP:  shadow_cfg.misc_map  = data[MAP_W-1:0];
            CFG_AUTO_CLR:  shadow_cfg.auto_clr  = data[NUM_VEC-1:0];
            CFG_AUTO_MSK:  shadow_cfg.auto_msk  = data[NUM_VEC-1:0];
            CFG_TBL_MASK:  shadow_cfg.tbl_mask  = data[NUM_VEC-1:0];
            default: begin
            end
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Present one event word, with random idle cycles ahead of it, until taken
    task automatic send_event(input logic [OP_W-1:0] op, input logic q,
                              input logic [NUM_VEC-1:0] bmap, input logic chk,
                              input t_evt_res res);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            evt_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        evt_if.valid <= 1'b1;
        evt_if.op    <= op;
        evt_if.queue <= q;
        evt_if.bits  <= bmap;
        cur_has_exp  <= chk;
        cur_exp      <= res;
        @(posedge i_clk);
        while (!evt_if.ready) @(posedge i_clk);
    endtask

    // Drop valid and hold until every pending result word has come back
    task automatic drain_results();
        @(negedge i_clk);
        evt_if.valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Receiver: stall at random
    always @(negedge i_clk) begin
        res_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Check results, record accepted events, watch for a hang
    always @(posedge i_clk) begin
        t_evt_res got;
        t_evt_res want;
        logic     progress;
        if (i_rst_n) begin
            progress = 1'b0;
            if (res_if.valid && res_if.ready) begin
                progress     = 1'b1;
                got.fired    = res_if.fired;
                got.cause    = res_if.cause_now;
                got.enable   = res_if.enable_now;
                if (expected_results.size() == 0) begin
                    report_mismatch("result word with no event pending", got, '0);
                end else begin
                    want = expected_results.pop_front();
                    if (got.fired !== want.fired || got.cause !== want.cause ||
                        got.enable !== want.enable)
                        report_mismatch("result word", got, want);
                end
            end
            if (evt_if.valid && evt_if.ready) begin
                progress = 1'b1;
                want = predict_event(evt_if.op, evt_if.queue, evt_if.bits);
                if (cur_has_exp) want = cur_exp;
                expected_results.push_back(want);
            end
            if (progress) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // Stimulus
    initial begin
        t_dir_row        row;
        logic [OP_W-1:0] op;
        int              r;
        t_cfg            rc;

        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_idx    = '0;
        i_cfg_wdata  = '0;
        evt_if.valid = 1'b0;
        evt_if.op    = '0;
        evt_if.queue = 1'b0;
        evt_if.bits  = '0;
        cur_has_exp  = 1'b0;
        cur_exp      = '0;

        shadow_cfg.queue_map = '0;
        shadow_cfg.misc_map  = '0;
        shadow_cfg.auto_clr  = '0;
        shadow_cfg.auto_msk  = '0;
        shadow_cfg.tbl_mask  = TBL_MASK_RST;
        shadow_cause         = '0;
        shadow_enable        = '0;

        // Reset state: nothing mapped, all vectors table masked
        dir_table.push_back(evt_row(OP_RX_EVT,    1'b0, 3'b111, 1'b1, {3'd0, 3'd0, 3'd0}));
        dir_table.push_back(evt_row(OP_TX_EVT,    1'b1, 3'b111, 1'b1, {3'd0, 3'd0, 3'd0}));
        dir_table.push_back(evt_row(OP_MISC_EVT,  1'b1, 3'b000, 1'b1, {3'd0, 3'd0, 3'd0}));
        dir_table.push_back(evt_row(OP_SET_EN,    1'b0, 3'b111, 1'b1, {3'd0, 3'd0, 3'd7}));
        dir_table.push_back(evt_row(OP_RETRIGGER, 1'b0, 3'b111, 1'b1, {3'd0, 3'd0, 3'd7}));
        dir_table.push_back(evt_row(OP_SPARE_6,   1'b1, 3'b111, 1'b1, {3'd0, 3'd0, 3'd7}));
        dir_table.push_back(evt_row(OP_SPARE_7,   1'b1, 3'b111, 1'b1, {3'd0, 3'd0, 3'd7}));
        // Map all queue events; queue 1 TX names the invalid vector code three
        dir_table.push_back(cfg_row(CFG_QUEUE_MAP, 32'h8382_8180));
        // Enabled but table masked: causes collect, nothing fires
        dir_table.push_back(evt_row(OP_RX_EVT,    1'b0, 3'b000, 1'b1, {3'd0, 3'd1, 3'd7}));
        dir_table.push_back(evt_row(OP_TX_EVT,    1'b0, 3'b000, 1'b1, {3'd0, 3'd3, 3'd7}));
        dir_table.push_back(evt_row(OP_RX_EVT,    1'b1, 3'b000, 1'b1, {3'd0, 3'd7, 3'd7}));
        dir_table.push_back(evt_row(OP_TX_EVT,    1'b1, 3'b111, 1'b1, {3'd0, 3'd7, 3'd7}));
        dir_table.push_back(evt_row(OP_RETRIGGER, 1'b1, 3'b000, 1'b1, {3'd0, 3'd7, 3'd7}));
        dir_table.push_back(evt_row(OP_CLR_CAUSE, 1'b0, 3'b111, 1'b1, {3'd0, 3'd0, 3'd7}));
        // Unmask, with wide data that must be cut to register width
        dir_table.push_back(cfg_row(CFG_TBL_MASK, 32'hFFFF_FFF8));
        dir_table.push_back(cfg_row(CFG_AUTO_CLR, 32'hFFFF_FFFF));
        dir_table.push_back(cfg_row(CFG_AUTO_MSK, 32'h0000_0005));
        dir_table.push_back(evt_row(OP_RX_EVT,    1'b0, 3'b000, 1'b0, '0));
        dir_table.push_back(evt_row(OP_TX_EVT,    1'b0, 3'b000, 1'b0, '0));
        dir_table.push_back(cfg_row(CFG_MISC_MAP, 32'hFFFF_FF82));
        dir_table.push_back(evt_row(OP_MISC_EVT,  1'b0, 3'b000, 1'b0, '0));
        dir_table.push_back(cfg_row(CFG_AUTO_CLR, 32'h0000_0000));
        dir_table.push_back(evt_row(OP_RX_EVT,    1'b1, 3'b000, 1'b0, '0));
        dir_table.push_back(evt_row(OP_SET_EN,    1'b0, 3'b101, 1'b0, '0));
        dir_table.push_back(evt_row(OP_RETRIGGER, 1'b0, 3'b000, 1'b0, '0));
        // Write to an unused index; invalid misc map; valid map naming invalid vector code three
        dir_table.push_back(cfg_row(CFG_IDX_NONE, 32'hFFFF_FFFF));
        dir_table.push_back(cfg_row(CFG_MISC_MAP, 32'h0000_007F));
        dir_table.push_back(evt_row(OP_MISC_EVT,  1'b0, 3'b000, 1'b0, '0));
        dir_table.push_back(cfg_row(CFG_MISC_MAP, 32'h0000_00FF));
        dir_table.push_back(evt_row(OP_MISC_EVT,  1'b1, 3'b111, 1'b0, '0));
        dir_table.push_back(evt_row(OP_CLR_CAUSE, 1'b1, 3'b010, 1'b0, '0));

        // Hold reset, then release
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table
        foreach (dir_table[k]) begin
            row = dir_table[k];
            if (row.is_cfg) begin
                drain_results();
                write_reg(row.code, row.wdata);
            end else begin
                send_event(row.code, row.queue, row.bits, row.check, row.res);
            end
        end

        // Random phases, each with its own setting and one of four idling patterns
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            drain_results();
            case (ph % 4)
                0: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    send_idle_pct  = 79;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 79;
                end
                default: begin
                    send_idle_pct  = 36;
                    recv_stall_pct = 36;
                end
            endcase
            if (ph == 0) begin
                rc.queue_map = 32'h8281_8280;
                rc.misc_map  = 8'h82;
                rc.auto_clr  = 3'b111;
                rc.auto_msk  = 3'b111;
                rc.tbl_mask  = 3'b000;
            end else if (ph == 1) begin
                rc.queue_map = '1;
                rc.misc_map  = '1;
                rc.auto_clr  = 3'b000;
                rc.auto_msk  = 3'b000;
                rc.tbl_mask  = 3'b111;
            end else begin
                rc.queue_map = {rand_map_byte(), rand_map_byte(), rand_map_byte(),
                                rand_map_byte()};
                rc.misc_map  = rand_map_byte();
                rc.auto_clr  = NUM_VEC'($urandom);
                rc.auto_msk  = NUM_VEC'($urandom);
                rc.tbl_mask  = ($urandom_range(1) == 0) ? 3'b000 : 3'($urandom);
            end
            write_reg(CFG_QUEUE_MAP, rc.queue_map);
            write_reg(CFG_MISC_MAP, {$urandom_range(1) ? 24'hFFFFFF : 24'h0, rc.misc_map});
            write_reg(CFG_AUTO_CLR, {29'($urandom), rc.auto_clr});
            write_reg(CFG_AUTO_MSK, {29'($urandom), rc.auto_msk});
            write_reg(CFG_TBL_MASK, {29'($urandom), rc.tbl_mask});

            for (int n = 0; n < WORDS_PER_PHASE; n++) begin
                r = $urandom_range(99);
                if (r < 20)      op = OP_RX_EVT;
                else if (r < 40) op = OP_TX_EVT;
                else if (r < 55) op = OP_MISC_EVT;
                else if (r < 65) op = OP_RETRIGGER;
                else if (r < 82) op = OP_SET_EN;
                else if (r < 94) op = OP_CLR_CAUSE;
                else if (r < 97) op = OP_SPARE_6;
                else             op = OP_SPARE_7;
                send_event(op, 1'($urandom), 3'($urandom), 1'b0, '0);
            end
        end

        // Wind down and report
        drain_results();
        repeat (8) @(posedge i_clk);
        if (err_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

@@ msix_interrupt_cause_mask_unit.f @@
+incdir+hdl
hdl/micm_pkg.sv
hdl/micm_in_if.sv
hdl/micm_out_if.sv
hdl/micm_core.sv
hdl/msix_interrupt_cause_mask_unit.sv
hdl/micm_checker.sv
tb/testbench.sv
